>>> hw/rtl/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg: shared types and helpers for the projection update engine
// Sizes, request and result codes, register indexes, sequencer states and
// the saturation helper used by the datapath.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 3;

  // Request codes
  typedef enum logic [2:0] {
    REQ_WR_WEIGHT = 3'd0,
    REQ_WR_ACT    = 3'd1,
    REQ_ERR_ELEM  = 3'd2,
    REQ_RD_ERR    = 3'd3,
    REQ_ADJUST    = 3'd4,
    REQ_RD_WEIGHT = 3'd5
  } req_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ERR    = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_ADJUST = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_LRATE    = 3'd0,
    CFG_DECAY    = 3'd1,
    CFG_MOMENTUM = 3'd2,
    CFG_ROWS     = 3'd3,
    CFG_COLS     = 3'd4
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_MUL,
    ST_ACC,
    ST_ADJ_RD,
    ST_ADJ_MUL,
    ST_ADJ_WB,
    ST_WRD,
    ST_DONE
  } state_t;

  // Per-row contents of one ring cell
  typedef struct packed {
    logic signed [DATA_W-1:0] act;
    logic signed [DATA_W-1:0] err;
  } cell_data_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bpu_ram.sv
// ----------------------------------------------------------------------------
// bpu_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module bpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/bpu_cell.sv
// ----------------------------------------------------------------------------
// bpu_cell: one cell of the row ring
// Holds one row's activation and error accumulator and takes its
// neighbor's contents whenever the ring rotates.
// ----------------------------------------------------------------------------
module bpu_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  bpu_pkg::cell_data_t   data_in,
  output bpu_pkg::cell_data_t   data_out
);

  bpu_pkg::cell_data_t data_r;
  bpu_pkg::cell_data_t data_nxt;

  // Hold or take the neighbor's row
  always_comb begin
    data_nxt = shift_en ? data_in : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_out = data_r;

endmodule

>>> hw/rtl/backprop_projection_update.sv
// ----------------------------------------------------------------------------
// backprop_projection_update: weight, delta and error engine for one projection
// Back-propagation with momentum over a 64 x 64 Q16.16 weight matrix.
// ----------------------------------------------------------------------------
// One item is worked at a time. Per-row activations and error accumulators
// live in a ring of 64 cells that turns one place per row step; weights,
// deltas and previous deltas sit in three 4096-entry RAMs with one read and
// one write port each. A weight write is done in the transfer itself. An
// activation write makes one full ring turn. A read error makes a ring turn
// and then passes through the finish state. An error element for a column
// in use makes a ring turn in which each used row needs a RAM read, a
// multiply and an accumulate step and every other row one ring step; a
// column out of use is done in the transfer itself. Adjust walks the used
// matrix entries, each with a read, a multiply and a write back, then the
// finish state. Read weight reads the RAM and then the finish state follows.
// After reset a clearing pass over all 4096 entries zeroes the delta stores;
// no item is taken until it ends, while configuration writes are taken at
// any time. A finished result waits in an output register, so the next item
// can start; the finish state stalls only while that register still holds a
// result not yet taken.
// ----------------------------------------------------------------------------
module backprop_projection_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_req_type,
  input  logic [bpu_pkg::ROW_W-1:0]         in_row_index,
  input  logic [bpu_pkg::COL_W-1:0]         in_col_index,
  input  logic signed [bpu_pkg::DATA_W-1:0] in_data_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpu_pkg::DATA_W-1:0] out_result_value,
  output logic [1:0]                        out_result_kind,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpu_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bpu_pkg::CFG_W-1:0]         cfg_data
);

  localparam int RW = bpu_pkg::ROW_W;
  localparam int CW = bpu_pkg::COL_W;
  localparam int AW = bpu_pkg::ADDR_W;
  localparam int DW = bpu_pkg::DATA_W;
  localparam int NW = bpu_pkg::CNT_W;

  bpu_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [bpu_pkg::CFG_W-1:0] lrate_r, decay_r, momentum_r;
  logic [NW-1:0]             rows_r, cols_r;
  logic [NW-1:0]             nr, nc;

  // Latched item
  logic [2:0]          req_r;
  logic [RW-1:0]       row_r;
  logic [CW-1:0]       col_r;
  logic signed [DW-1:0] data_r;

  // Counters
  logic [AW-1:0] clr_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [CW-1:0] col_cnt_r;

  // Datapath registers
  logic signed [63:0] p_err_r, p_del_r;
  logic signed [63:0] m_lr_r, m_dc_r, m_mo_r;
  logic signed [DW-1:0] res_val_r;
  logic [1:0]           res_kind_r;
  logic                 out_valid_r;
  logic signed [DW-1:0] out_val_r;
  logic [1:0]           out_kind_r;

  // RAM ports
  logic          w_we, d_we, p_we, w_re, d_re, p_re;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] w_wdata, d_wdata, p_wdata;
  logic [DW-1:0] w_rd, d_rd, p_rd;

  // Ring
  bpu_pkg::cell_data_t cell_q [bpu_pkg::MAX_ROWS];
  bpu_pkg::cell_data_t head, ring_in;
  logic                shift_en;

  logic in_xfer, out_free, mac_step, last_row, adj_last;
  logic signed [DW-1:0] err_new, del_new, w_new;
  logic signed [63:0]   adj_sum;

  assign in_ready  = (state_r == bpu_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Used sizes, clamped to the store size
  assign nr = (rows_r > NW'(bpu_pkg::MAX_ROWS)) ? NW'(bpu_pkg::MAX_ROWS) : rows_r;
  assign nc = (cols_r > NW'(bpu_pkg::MAX_COLS)) ? NW'(bpu_pkg::MAX_COLS) : cols_r;

  assign head     = cell_q[0];
  assign mac_step = (req_r == bpu_pkg::REQ_ERR_ELEM) && ({1'b0, row_cnt_r} < nr);
  assign last_row = (row_cnt_r == RW'(bpu_pkg::MAX_ROWS - 1));
  assign adj_last = ({1'b0, col_cnt_r} == nc - NW'(1)) && ({1'b0, row_cnt_r} == nr - NW'(1));

  // Accumulate and weight update arithmetic (shift right floors)
  assign err_new = bpu_pkg::sat32($signed({{32{head.err[DW-1]}}, head.err}) + (p_err_r >>> 16));
  assign del_new = bpu_pkg::sat32($signed({{32{d_rd[DW-1]}}, d_rd}) + (p_del_r >>> 16));
  assign adj_sum = m_lr_r - m_dc_r + m_mo_r;
  assign w_new   = bpu_pkg::sat32($signed({{32{w_rd[DW-1]}}, w_rd}) + (adj_sum >>> 16));

  // Ring head input: activation write or updated error
  always_comb begin
    ring_in = head;
    if (state_r == bpu_pkg::ST_ROW && req_r == bpu_pkg::REQ_WR_ACT && row_cnt_r == row_r) begin
      ring_in.act = data_r;
      ring_in.err = '0;
    end
    if (state_r == bpu_pkg::ST_ACC) begin
      ring_in.err = err_new;
    end
  end

  assign shift_en = (state_r == bpu_pkg::ST_ROW && !mac_step) || (state_r == bpu_pkg::ST_ACC);

  // Row ring of cells
  for (genvar g = 0; g < bpu_pkg::MAX_ROWS; g++) begin : g_cell
    if (g == bpu_pkg::MAX_ROWS - 1) begin : g_tail
      bpu_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
        .data_in(ring_in), .data_out(cell_q[g])
      );
    end else begin : g_body
      bpu_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
        .data_in(cell_q[g+1]), .data_out(cell_q[g])
      );
    end
  end

  // Matrix stores
  bpu_ram #(.WIDTH(DW), .DEPTH(bpu_pkg::DEPTH)) u_weight (
    .clk(clk), .wr_en(w_we), .wr_addr(wr_addr), .wr_data(w_wdata),
    .rd_en(w_re), .rd_addr(rd_addr), .rd_data(w_rd)
  );
  bpu_ram #(.WIDTH(DW), .DEPTH(bpu_pkg::DEPTH)) u_delta (
    .clk(clk), .wr_en(d_we), .wr_addr(wr_addr), .wr_data(d_wdata),
    .rd_en(d_re), .rd_addr(rd_addr), .rd_data(d_rd)
  );
  bpu_ram #(.WIDTH(DW), .DEPTH(bpu_pkg::DEPTH)) u_prev (
    .clk(clk), .wr_en(p_we), .wr_addr(wr_addr), .wr_data(p_wdata),
    .rd_en(p_re), .rd_addr(rd_addr), .rd_data(p_rd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpu_pkg::ST_CLEAR: begin
        if (&clr_cnt_r) state_nxt = bpu_pkg::ST_IDLE;
      end
      bpu_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            bpu_pkg::REQ_WR_ACT, bpu_pkg::REQ_RD_ERR: state_nxt = bpu_pkg::ST_ROW;
            bpu_pkg::REQ_ERR_ELEM: begin
              if ({1'b0, in_col_index} < nc) state_nxt = bpu_pkg::ST_ROW;
            end
            bpu_pkg::REQ_ADJUST: begin
              state_nxt = (nr == '0 || nc == '0) ? bpu_pkg::ST_DONE : bpu_pkg::ST_ADJ_RD;
            end
            bpu_pkg::REQ_RD_WEIGHT: state_nxt = bpu_pkg::ST_WRD;
            default: state_nxt = bpu_pkg::ST_IDLE;
          endcase
        end
      end
      bpu_pkg::ST_ROW: begin
        if (mac_step) begin
          state_nxt = bpu_pkg::ST_MUL;
        end else if (last_row) begin
          state_nxt = (req_r == bpu_pkg::REQ_RD_ERR) ? bpu_pkg::ST_DONE : bpu_pkg::ST_IDLE;
        end
      end
      bpu_pkg::ST_MUL:     state_nxt = bpu_pkg::ST_ACC;
      bpu_pkg::ST_ACC:     state_nxt = last_row ? bpu_pkg::ST_IDLE : bpu_pkg::ST_ROW;
      bpu_pkg::ST_ADJ_RD:  state_nxt = bpu_pkg::ST_ADJ_MUL;
      bpu_pkg::ST_ADJ_MUL: state_nxt = bpu_pkg::ST_ADJ_WB;
      bpu_pkg::ST_ADJ_WB:  state_nxt = adj_last ? bpu_pkg::ST_DONE : bpu_pkg::ST_ADJ_RD;
      bpu_pkg::ST_WRD:     state_nxt = bpu_pkg::ST_DONE;
      bpu_pkg::ST_DONE: begin
        if (out_free) state_nxt = bpu_pkg::ST_IDLE;
      end
      default: state_nxt = bpu_pkg::ST_IDLE;
    endcase
  end

  // Store controls
  always_comb begin
    w_we = 1'b0; d_we = 1'b0; p_we = 1'b0;
    w_re = 1'b0; d_re = 1'b0; p_re = 1'b0;
    wr_addr = {row_cnt_r, col_cnt_r};
    rd_addr = {row_cnt_r, col_cnt_r};
    w_wdata = w_new;
    d_wdata = '0;
    p_wdata = '0;
    case (state_r)
      bpu_pkg::ST_CLEAR: begin
        d_we = 1'b1;
        p_we = 1'b1;
        wr_addr = clr_cnt_r;
      end
      bpu_pkg::ST_IDLE: begin
        if (in_xfer && in_req_type == bpu_pkg::REQ_WR_WEIGHT) begin
          w_we = 1'b1;
          wr_addr = {in_row_index, in_col_index};
          w_wdata = in_data_value;
        end
        if (in_xfer && in_req_type == bpu_pkg::REQ_RD_WEIGHT) begin
          w_re = 1'b1;
          rd_addr = {in_row_index, in_col_index};
        end
      end
      bpu_pkg::ST_ROW: begin
        rd_addr = {row_cnt_r, col_r};
        if (mac_step) begin
          w_re = 1'b1;
          d_re = 1'b1;
        end
      end
      bpu_pkg::ST_ACC: begin
        d_we = 1'b1;
        wr_addr = {row_cnt_r, col_r};
        d_wdata = del_new;
      end
      bpu_pkg::ST_ADJ_RD: begin
        w_re = 1'b1;
        d_re = 1'b1;
        p_re = 1'b1;
      end
      bpu_pkg::ST_ADJ_WB: begin
        w_we = 1'b1;
        d_we = 1'b1;
        p_we = 1'b1;
        p_wdata = d_rd;
      end
      default: begin
        w_we = 1'b0;
      end
    endcase
  end

  // State, configuration and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpu_pkg::ST_CLEAR;
      lrate_r     <= '0;
      decay_r     <= '0;
      momentum_r  <= '0;
      rows_r      <= NW'(64);
      cols_r      <= NW'(64);
      clr_cnt_r   <= '0;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Configuration transfer
      if (cfg_valid) begin
        case (cfg_index)
          bpu_pkg::CFG_LRATE:    lrate_r    <= cfg_data;
          bpu_pkg::CFG_DECAY:    decay_r    <= cfg_data;
          bpu_pkg::CFG_MOMENTUM: momentum_r <= cfg_data;
          bpu_pkg::CFG_ROWS:     rows_r     <= cfg_data[NW-1:0];
          bpu_pkg::CFG_COLS:     cols_r     <= cfg_data[NW-1:0];
          default: ;
        endcase
      end
      // Clearing sweep
      if (state_r == bpu_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      // Ring step counter
      if (shift_en) row_cnt_r <= last_row ? '0 : row_cnt_r + RW'(1);
      // Adjust walk
      if (state_r == bpu_pkg::ST_ADJ_WB) begin
        if ({1'b0, col_cnt_r} == nc - NW'(1)) begin
          col_cnt_r <= '0;
          row_cnt_r <= ({1'b0, row_cnt_r} == nr - NW'(1)) ? '0 : row_cnt_r + RW'(1);
        end else begin
          col_cnt_r <= col_cnt_r + CW'(1);
        end
      end
      // Output register
      if (state_r == bpu_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r  <= in_req_type;
      row_r  <= in_row_index;
      col_r  <= in_col_index;
      data_r <= in_data_value;
      if (in_req_type == bpu_pkg::REQ_ADJUST) begin
        res_val_r  <= '0;
        res_kind_r <= bpu_pkg::KIND_ADJUST;
      end
    end
    if (state_r == bpu_pkg::ST_ROW && req_r == bpu_pkg::REQ_RD_ERR && row_cnt_r == row_r) begin
      res_val_r  <= head.err;
      res_kind_r <= bpu_pkg::KIND_ERR;
    end
    if (state_r == bpu_pkg::ST_WRD) begin
      res_val_r  <= w_rd;
      res_kind_r <= bpu_pkg::KIND_WEIGHT;
    end
    if (state_r == bpu_pkg::ST_MUL) begin
      p_err_r <= $signed(w_rd) * data_r;
      p_del_r <= head.act * data_r;
    end
    if (state_r == bpu_pkg::ST_ADJ_MUL) begin
      m_lr_r <= 64'($signed({1'b0, lrate_r}) * $signed(d_rd));
      m_dc_r <= 64'($signed({1'b0, decay_r}) * $signed(p_rd));
      m_mo_r <= 64'($signed({1'b0, momentum_r}) * $signed(p_rd));
    end
    if (state_r == bpu_pkg::ST_DONE && out_free) begin
      out_val_r  <= res_val_r;
      out_kind_r <= res_kind_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_result_kind  = out_kind_r;

  // A result appears only after the sequencer finishes an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bpu_pkg::ST_DONE))
    else $error("result loaded outside the finish state");

  // The ring is back in place whenever the block waits for an item
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpu_pkg::ST_IDLE) |-> (row_cnt_r == '0 && col_cnt_r == '0))
    else $error("row ring left out of place");

  // Delta accumulation only for a column in use
  a_acc_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpu_pkg::ST_ACC) |-> ({1'b0, col_r} < nc && {1'b0, row_cnt_r} < nr))
    else $error("accumulate outside the used region");

  // Multiply is always followed by its write back
  a_mul_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpu_pkg::ST_MUL) |=> (state_r == bpu_pkg::ST_ACC && $stable(row_cnt_r)))
    else $error("multiply step lost its write back");

endmodule

>>> verif/backprop_projection_update_checker.sv
// ----------------------------------------------------------------------------
// backprop_projection_update_checker: result predictor and comparator
// Follows every transfer on the config, request and result channels, keeps its
// own copy of the weight, delta, activation and error state, and checks each
// result against the oldest predicted one.
// ----------------------------------------------------------------------------
module backprop_projection_update_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [2:0]                        in_req_type,
  input  logic [bpu_pkg::ROW_W-1:0]         in_row_index,
  input  logic [bpu_pkg::COL_W-1:0]         in_col_index,
  input  logic signed [bpu_pkg::DATA_W-1:0] in_data_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [bpu_pkg::DATA_W-1:0] out_result_value,
  input  logic [1:0]                        out_result_kind,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bpu_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bpu_pkg::CFG_W-1:0]         cfg_data,
  output int                                failures,
  output int                                pending
);

  localparam int DW = bpu_pkg::DATA_W;

  typedef struct {
    logic signed [DW-1:0] value;
    bpu_pkg::kind_t       kind;
  } readout_t;

  readout_t readout_q[$];

  logic signed [DW-1:0] weight_mem[bpu_pkg::DEPTH];
  logic signed [DW-1:0] delta_mem[bpu_pkg::DEPTH];
  logic signed [DW-1:0] prev_delta_mem[bpu_pkg::DEPTH];
  logic signed [DW-1:0] act_mem[bpu_pkg::MAX_ROWS];
  logic signed [DW-1:0] err_acc[bpu_pkg::MAX_ROWS];

  logic [bpu_pkg::CFG_W-1:0] lrate, decay, momentum;
  logic [bpu_pkg::CNT_W-1:0] rows_cfg, cols_cfg;

  function automatic logic signed [DW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DW-1:0];
  endfunction

  // Q16.16 multiply-accumulate, product floored to 16 fraction bits
  function automatic logic signed [DW-1:0] mac16(logic signed [DW-1:0] acc,
                                                  logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return clamp32(longint'(acc) + (prod >>> 16));
  endfunction

  // Apply one request to the shadow state and queue its readout
  task automatic apply_request(logic [2:0] req, logic [bpu_pkg::ROW_W-1:0] row,
                               logic [bpu_pkg::COL_W-1:0] col, logic signed [DW-1:0] data);
    int nr, nc, k;
    longint sum;
    readout_t r;
    nr = (rows_cfg > bpu_pkg::MAX_ROWS) ? bpu_pkg::MAX_ROWS : rows_cfg;
    nc = (cols_cfg > bpu_pkg::MAX_COLS) ? bpu_pkg::MAX_COLS : cols_cfg;
    case (req)
      bpu_pkg::REQ_WR_WEIGHT: weight_mem[{row, col}] = data;
      bpu_pkg::REQ_WR_ACT: begin
        act_mem[row] = data;
        err_acc[row] = '0;
      end
      bpu_pkg::REQ_ERR_ELEM: begin
        if (col < nc) begin
          for (int i = 0; i < nr; i++) begin
            k = i * bpu_pkg::MAX_COLS + col;
            err_acc[i]   = mac16(err_acc[i], weight_mem[k], data);
            delta_mem[k] = mac16(delta_mem[k], act_mem[i], data);
          end
        end
      end
      bpu_pkg::REQ_RD_ERR: begin
        r.value = err_acc[row];
        r.kind  = bpu_pkg::KIND_ERR;
        readout_q.push_back(r);
      end
      bpu_pkg::REQ_ADJUST: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            k = i * bpu_pkg::MAX_COLS + j;
            sum = longint'(lrate) * longint'(delta_mem[k])
                - longint'(decay) * longint'(prev_delta_mem[k])
                + longint'(momentum) * longint'(prev_delta_mem[k]);
            weight_mem[k]     = clamp32(longint'(weight_mem[k]) + (sum >>> 16));
            prev_delta_mem[k] = delta_mem[k];
            delta_mem[k]      = '0;
          end
        end
        r.value = '0;
        r.kind  = bpu_pkg::KIND_ADJUST;
        readout_q.push_back(r);
      end
      bpu_pkg::REQ_RD_WEIGHT: begin
        r.value = weight_mem[{row, col}];
        r.kind  = bpu_pkg::KIND_WEIGHT;
        readout_q.push_back(r);
      end
      default: ;  // unknown request codes are dropped
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bpu_pkg::DEPTH; k++) begin
        weight_mem[k]     = '0;
        delta_mem[k]      = '0;
        prev_delta_mem[k] = '0;
      end
      for (int i = 0; i < bpu_pkg::MAX_ROWS; i++) begin
        act_mem[i] = '0;
        err_acc[i] = '0;
      end
      lrate    = '0;
      decay    = '0;
      momentum = '0;
      rows_cfg = 7'd64;
      cols_cfg = 7'd64;
      readout_q.delete();
      failures = 0;
    end else begin
      // config transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpu_pkg::CFG_LRATE:    lrate    = cfg_data;
          bpu_pkg::CFG_DECAY:    decay    = cfg_data;
          bpu_pkg::CFG_MOMENTUM: momentum = cfg_data;
          bpu_pkg::CFG_ROWS:     rows_cfg = cfg_data[bpu_pkg::CNT_W-1:0];
          bpu_pkg::CFG_COLS:     cols_cfg = cfg_data[bpu_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      // result transfer, compared before this edge's request adds to the queue
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          $error("unexpected result: result_value %0d result_kind %0d",
                 out_result_value, out_result_kind);
          failures++;
        end else begin
          readout_t exp_r;
          exp_r = readout_q.pop_front();
          if (out_result_value !== exp_r.value) begin
            $error("result_value: expected %0d, got %0d", exp_r.value, out_result_value);
            failures++;
          end
          if (out_result_kind !== exp_r.kind) begin
            $error("result_kind: expected %0d, got %0d", exp_r.kind, out_result_kind);
            failures++;
          end
        end
      end
      // request transfer
      if (in_valid && in_ready)
        apply_request(in_req_type, in_row_index, in_col_index, in_data_value);
    end
    pending = readout_q.size();
  end

endmodule

>>> verif/backprop_projection_update_tb.sv
// ----------------------------------------------------------------------------
// backprop_projection_update_tb: stimulus and verdict for the projection engine
// Fills the first weight columns and every activation, runs directed corner
// requests, then random phases under changing learning settings and sizes
// with random gaps on both channels; the checker beside the block predicts
// and compares.
// ----------------------------------------------------------------------------
module backprop_projection_update_tb;

  localparam int RW = bpu_pkg::ROW_W;
  localparam int CW = bpu_pkg::COL_W;
  localparam int DW = bpu_pkg::DATA_W;
  localparam int NW = bpu_pkg::CNT_W;
  localparam int XW = bpu_pkg::CFG_W;

  localparam logic [2:0]                REQ_SPARE_A = 3'd6;
  localparam logic [2:0]                REQ_SPARE_B = 3'd7;
  localparam logic [bpu_pkg::IDX_W-1:0] CFG_SPARE   = 3'd5;
  localparam logic [XW-1:0]             RATE_MAX    = 24'hFFFFFF;
  localparam int                        SETTLE      = 300;
  localparam int                        IDLE_LIMIT  = 20000;
  localparam int                        PHASES      = 12;
  localparam int                        PHASE_ITEMS = 80;
  // weight columns written up front; random weight reads stay below this
  localparam int                        FILL_COLS   = 8;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_req_type = '0;
  logic [RW-1:0]            in_row_index = '0;
  logic [CW-1:0]            in_col_index = '0;
  logic signed [DW-1:0]     in_data_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DW-1:0]     out_result_value;
  logic [1:0]               out_result_kind;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [bpu_pkg::IDX_W-1:0] cfg_index = '0;
  logic [XW-1:0]            cfg_data = '0;

  int failures, pending;
  int idle_cycles = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;
  int rows_now = 64, cols_now = 64;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  backprop_projection_update i_dut (.*);

  backprop_projection_update_checker i_checker (.*);

  // Mostly short gaps, a few long ones, none at all in burst stretches
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("backprop_projection_update: mismatch");
      $finish;
    end
  end

  task automatic send(logic [2:0] req, logic [RW-1:0] row, logic [CW-1:0] col,
                      logic signed [DW-1:0] data);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_row_index  <= row;
    in_col_index  <= col;
    in_data_value <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every result plus the tail of a silent item
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [bpu_pkg::IDX_W-1:0] idx, logic [XW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [XW-1:0] lr, logic [XW-1:0] dc, logic [XW-1:0] mo,
                            logic [NW-1:0] rows, logic [NW-1:0] cols);
    cfg_write(bpu_pkg::CFG_LRATE, lr);
    cfg_write(bpu_pkg::CFG_DECAY, dc);
    cfg_write(bpu_pkg::CFG_MOMENTUM, mo);
    cfg_write(bpu_pkg::CFG_ROWS, {17'd0, rows});
    cfg_write(bpu_pkg::CFG_COLS, {17'd0, cols});
    cfg_valid <= 1'b0;
    @(posedge clk);
    rows_now = (rows > bpu_pkg::MAX_ROWS) ? bpu_pkg::MAX_ROWS : rows;
    cols_now = (cols > bpu_pkg::MAX_COLS) ? bpu_pkg::MAX_COLS : cols;
  endtask

  function automatic logic signed [DW-1:0] rand_data();
    if ($urandom_range(0, 99) < 35) return $urandom;
    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic logic [RW-1:0] rand_row();
    return RW'($urandom);
  endfunction

  function automatic logic [CW-1:0] rand_col();
    return CW'($urandom);
  endfunction

  // One random request, adjust only where the region is cheap
  task automatic rand_request();
    int r, adj_w;
    logic [CW-1:0] col;
    adj_w = (rows_now * cols_now <= 256) ? 4 : 0;
    r = $urandom_range(0, 99);
    col = rand_col();
    if (r < 18) send(bpu_pkg::REQ_WR_WEIGHT, rand_row(), rand_col(), rand_data());
    else if (r < 27) send(bpu_pkg::REQ_WR_ACT, rand_row(), rand_col(), rand_data());
    else if (r < 55) begin
      if (cols_now > 0 && $urandom_range(0, 9) < 8) col = CW'($urandom_range(0, cols_now - 1));
      send(bpu_pkg::REQ_ERR_ELEM, rand_row(), col, rand_data());
    end
    else if (r < 72) send(bpu_pkg::REQ_RD_ERR, rand_row(), rand_col(), rand_data());
    else if (r < 72 + adj_w) send(bpu_pkg::REQ_ADJUST, rand_row(), rand_col(), rand_data());
    else if (r < 98) send(bpu_pkg::REQ_RD_WEIGHT, rand_row(),
                          CW'($urandom_range(0, FILL_COLS - 1)), rand_data());
    else send($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B, rand_row(), rand_col(),
              rand_data());
  endtask

  initial begin
    logic [NW-1:0] rows, cols;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill the first weight columns and every activation
    no_gaps = 1'b1;
    for (int i = 0; i < bpu_pkg::MAX_ROWS; i++)
      for (int j = 0; j < FILL_COLS; j++)
        send(bpu_pkg::REQ_WR_WEIGHT, RW'(i), CW'(j), rand_data());
    for (int i = 0; i < bpu_pkg::MAX_ROWS; i++)
      send(bpu_pkg::REQ_WR_ACT, RW'(i), rand_col(), rand_data());
    no_gaps = 1'b0;

    // directed: field extremes, saturation, every request code
    send(bpu_pkg::REQ_WR_WEIGHT, 6'd0, 6'd0, 32'sh7FFFFFFF);
    send(bpu_pkg::REQ_WR_WEIGHT, 6'd63, 6'd63, 32'sh80000000);
    send(bpu_pkg::REQ_RD_WEIGHT, 6'd0, 6'd0, 32'sd0);
    send(bpu_pkg::REQ_RD_WEIGHT, 6'd63, 6'd63, 32'sd0);
    send(bpu_pkg::REQ_WR_ACT, 6'd0, 6'd0, 32'sh7FFFFFFF);
    send(bpu_pkg::REQ_WR_ACT, 6'd63, 6'd0, 32'sh80000000);
    send(bpu_pkg::REQ_ERR_ELEM, 6'd0, 6'd0, 32'sh7FFFFFFF);
    send(bpu_pkg::REQ_ERR_ELEM, 6'd0, CW'(FILL_COLS - 1), 32'sh80000000);
    send(bpu_pkg::REQ_RD_ERR, 6'd0, 6'd0, 32'sd0);
    send(bpu_pkg::REQ_RD_ERR, 6'd63, 6'd0, 32'sd0);
    send(REQ_SPARE_A, 6'd5, 6'd5, 32'sh7FFFFFFF);
    send(REQ_SPARE_B, 6'd5, 6'd5, 32'sh80000000);
    drain();
    set_config(24'd0, 24'd0, 24'd0, 7'd64, NW'(FILL_COLS));
    send(bpu_pkg::REQ_ADJUST, 6'd0, 6'd0, 32'sd0);
    send(bpu_pkg::REQ_RD_WEIGHT, 6'd0, 6'd0, 32'sd0);
    drain();

    // directed under maximal rates on a one-entry region
    set_config(RATE_MAX, RATE_MAX, RATE_MAX, 7'd1, 7'd1);
    send(bpu_pkg::REQ_ERR_ELEM, 6'd0, 6'd0, 32'sh00010000);
    send(bpu_pkg::REQ_ERR_ELEM, 6'd0, 6'd5, 32'sh00010000);  // column outside region
    send(bpu_pkg::REQ_ADJUST, 6'd0, 6'd0, 32'sd0);
    send(bpu_pkg::REQ_ERR_ELEM, 6'd0, 6'd0, -32'sh00020000);
    send(bpu_pkg::REQ_ADJUST, 6'd0, 6'd0, 32'sd0);
    send(bpu_pkg::REQ_RD_WEIGHT, 6'd0, 6'd0, 32'sd0);
    send(bpu_pkg::REQ_RD_WEIGHT, 6'd0, 6'd1, 32'sd0);
    drain();

    // random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(RATE_MAX, 24'd0, RATE_MAX, 7'd64, NW'(FILL_COLS));
        1: set_config(RATE_MAX, RATE_MAX, RATE_MAX, 7'd0, 7'd100);
        2: set_config(XW'($urandom), XW'($urandom), XW'($urandom), 7'd127, 7'd0);
        default: begin
          rows = ($urandom_range(0, 3) == 0) ? NW'($urandom_range(1, 64))
                                             : NW'($urandom_range(1, 8));
          cols = NW'($urandom_range(1, FILL_COLS));
          set_config(XW'($urandom_range(0, 1 << 17)), XW'($urandom_range(0, 1 << 16)),
                     XW'($urandom_range(0, 1 << 16)), rows, cols);
        end
      endcase
      if (p == 3) begin
        cfg_write(CFG_SPARE, XW'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      no_gaps = (p % 4 == 1);
      if (p == 0) send(bpu_pkg::REQ_ADJUST, 6'd0, 6'd0, 32'sd0);  // adjust over the filled region
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        rand_request();
      end
      drain();
    end

    if (failures == 0)
      $display("backprop_projection_update: match");
    else
      $display("backprop_projection_update: mismatch");
    $finish;
  end

endmodule
